// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

// ----- rtl/core/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int MAG_W    = OUT_W + 1;   // saturated magnitude, at most 32768
    localparam int NUM_COMP = 4;

    localparam int COMP_X = 0;
    localparam int COMP_Y = 1;
    localparam int COMP_Z = 2;
    localparam int COMP_W = 3;

    // Per-item side information that travels down the whole pipeline.
    typedef struct packed {
        logic [NUM_COMP-1:0] neg;   // component sign
        logic                bad;   // scale not positive, result is identity
    } side_t;

endpackage

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// Throughput: one matrix per cycle while m_tready is high; every stage is a register
// and the pipeline closes gaps on its own while the output side stalls.
// Reset clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q1.14 rotation matrix to a normalized quaternion (Shepperd).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up, 16 bits each
    input  logic [143:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // quat_x, quat_y, quat_z, quat_w from the lowest bit up, 16 bits each
    output logic [63:0]    m_tdata
);

    // Width of the unnormalized vector components, wide enough for the scale d.
    localparam int VW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int NW = 2 * VW;          // squared length
    localparam int LW = VW;              // root width
    localparam int QW = FRAC_BITS + 1;   // quotient width
    localparam int D0 = 3 + LW;          // first divider stage
    localparam int T  = D0 + QW + 2;     // total stages, output register last

    // Stage control. A stage loads when it is empty or the stage after it moves,
    // so bubbles collapse and the input keeps flowing behind a stalled output.
    logic [T-1:0] vld_reg;
    logic [T:0]   en;

    assign en[T] = m_tready;
    genvar k;
    generate
        for (k = 0; k < T; k++)
        begin : g_ctl
            assign en[k] = ~vld_reg[k] | en[k+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en[k])
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[T-1];

    // ---------------- Stage 0: branch selection and vector setup ----------------
    logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    assign m00 = s_tdata[15:0];
    assign m01 = s_tdata[31:16];
    assign m02 = s_tdata[47:32];
    assign m10 = s_tdata[63:48];
    assign m11 = s_tdata[79:64];
    assign m12 = s_tdata[95:80];
    assign m20 = s_tdata[111:96];
    assign m21 = s_tdata[127:112];
    assign m22 = s_tdata[143:128];

    localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] trace, d;
    logic signed [VW-1:0] v [NUM_COMP];
    logic [VW-1:0]        mag0 [NUM_COMP];
    side_t                side0;

    always_comb
    begin
        e00 = VW'(m00); e01 = VW'(m01); e02 = VW'(m02);
        e10 = VW'(m10); e11 = VW'(m11); e12 = VW'(m12);
        e20 = VW'(m20); e21 = VW'(m21); e22 = VW'(m22);
        trace = e00 + e11 + e22;
        if (trace > 0)
        begin
            d         = ONE + trace;
            v[COMP_W] = d;
            v[COMP_X] = e21 - e12;
            v[COMP_Y] = e02 - e20;
            v[COMP_Z] = e10 - e01;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            d         = ONE + e00 - e11 - e22;
            v[COMP_X] = d;
            v[COMP_W] = e21 - e12;
            v[COMP_Y] = e01 + e10;
            v[COMP_Z] = e02 + e20;
        end
        else if (m11 > m22)
        begin
            d         = ONE + e11 - e00 - e22;
            v[COMP_Y] = d;
            v[COMP_W] = e02 - e20;
            v[COMP_X] = e01 + e10;
            v[COMP_Z] = e12 + e21;
        end
        else
        begin
            d         = ONE + e22 - e00 - e11;
            v[COMP_Z] = d;
            v[COMP_W] = e10 - e01;
            v[COMP_X] = e02 + e20;
            v[COMP_Y] = e12 + e21;
        end
        // A scale that is not positive means the input was no rotation.
        side0.bad = (d <= 0);
        for (int c = 0; c < NUM_COMP; c++)
        begin
            side0.neg[c] = v[c][VW-1];
            mag0[c]      = v[c][VW-1] ? VW'(-v[c]) : VW'(v[c]);
        end
    end

    // Side information runs the full length; magnitudes run up to the dividers.
    side_t         side_reg [T];
    logic [VW-1:0] mag_reg  [D0][NUM_COMP];

    generate
        for (k = 0; k < T; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en[k])
                    side_reg[k] <= (k == 0) ? side0 : side_reg[(k == 0) ? 0 : k-1];
            end
        end
        for (k = 0; k < D0; k++)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    for (int c = 0; c < NUM_COMP; c++)
                        mag_reg[k][c] <= (k == 0) ? mag0[c] : mag_reg[(k == 0) ? 0 : k-1][c];
                end
            end
        end
    endgenerate

    // ---------------- Stage 1: squares; stage 2: squared length ----------------
    logic [NW-1:0] sq_reg [NUM_COMP];
    logic [NW-1:0] n_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int c = 0; c < NUM_COMP; c++)
                sq_reg[c] <= NW'(mag_reg[0][c]) * NW'(mag_reg[0][c]);
        end
        if (en[2])
            n_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
    end

    // ---------------- Stages 3 .. D0-1: length by square root ----------------
    logic [LW-1:0] len;

    rmq_isqrt #(
        .NW (NW),
        .LW (LW)
    ) u_isqrt (
        .clk      (clk),
        .en       (en[3 +: LW]),
        .radicand (n_reg),
        .root     (len)
    );

    // ---------------- Stages D0 .. D0+QW: one divider per component ----------------
    logic [MAG_W-1:0] quot [NUM_COMP];

    genvar c;
    generate
        for (c = 0; c < NUM_COMP; c++)
        begin : g_div
            rmq_divider #(
                .FRAC_BITS (FRAC_BITS),
                .VW        (VW)
            ) u_div (
                .clk  (clk),
                .en   (en[D0 +: QW + 1]),
                .mag  (mag_reg[D0-1][c]),
                .len  (len),
                .quot (quot[c])
            );
        end
    endgenerate

    // ---------------- Last stage: sign, saturation and identity fallback ----------------
    localparam logic [OUT_W-1:0] ID_W = (FRAC_BITS >= 15) ? OUT_W'(32767)
                                                           : OUT_W'(1 << FRAC_BITS);

    side_t            side_f;
    logic [OUT_W-1:0] res [NUM_COMP];
    logic [OUT_W-1:0] out_reg [NUM_COMP];

    assign side_f = side_reg[T-2];

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (side_f.bad)
                res[i] = (i == COMP_W) ? ID_W : '0;
            else if (side_f.neg[i])
                res[i] = OUT_W'(MAG_W'(0) - quot[i]);
            else if (quot[i] > MAG_W'(32767))
                res[i] = OUT_W'(32767);
            else
                res[i] = quot[i][OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[T-1])
        begin
            for (int i = 0; i < NUM_COMP; i++)
                out_reg[i] <= res[i];
        end
    end

    assign m_tdata = {out_reg[COMP_W], out_reg[COMP_Z], out_reg[COMP_Y], out_reg[COMP_X]};

    // The input side only stalls when every stage holds a beat and the output waits.
    `ASSERT_PROP(a_stall_cause, clk, rst_n, !s_tready |-> (m_tvalid && !m_tready && (&vld_reg)), "input stalled without a full, blocked pipeline")
    // A matrix that is no rotation must leave as the identity quaternion.
    `ASSERT_PROP(a_identity, clk, rst_n, (m_tvalid && side_reg[T-1].bad) |-> (m_tdata[47:0] == 48'd0 && m_tdata[63:48] == ID_W), "identity fallback not applied")
    // A normalized vector always has a component of at least half scale.
    `ASSERT_NEVER(a_nonzero, clk, rst_n, m_tvalid && !side_reg[T-1].bad && m_tdata == 64'd0, "normalized quaternion came out all zero")
    // A beat that waits at the output stays there until it is taken.
    `ASSERT_PROP(a_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "waiting output beat changed")

endmodule

// ----- rtl/core/rmq_isqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_isqrt #(
    parameter int NW = 38,
    parameter int LW = 19
) (
    input  logic          clk,
    input  logic [LW-1:0] en,
    input  logic [NW-1:0] radicand,
    output logic [LW-1:0] root
);

    localparam int TW = NW + 2;

    logic [NW-1:0] rem_reg  [LW];
    logic [LW-1:0] root_reg [LW];

    genvar i;
    generate
        for (i = 0; i < LW; i++)
        begin : g_step
            localparam int B = LW - 1 - i;
            logic [NW-1:0] rem_in;
            logic [LW-1:0] root_in;
            logic [TW-1:0] trial;
            logic [NW-1:0] rem_next;
            logic [LW-1:0] root_next;

            if (i == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
            end

            always_comb
            begin
                trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
                if (TW'(rem_in) >= trial)
                begin
                    rem_next  = NW'(TW'(rem_in) - trial);
                    root_next = root_in | (LW'(1) << B);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[LW-1];

endmodule

// ----- rtl/core/rmq_divider.sv -----
// ----------------------------------------------------------------------------
// rmq_divider
// Pipelined restoring divider: round(mag * 2^FRAC_BITS / len), saturated.
// ----------------------------------------------------------------------------
module rmq_divider
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int VW        = 20
) (
    input  logic             clk,
    input  logic [FRAC_BITS+1:0] en,       // stage enables, numerator stage first
    input  logic [VW-1:0]    mag,
    input  logic [VW-1:0]    len,
    output logic [MAG_W-1:0] quot
);

    localparam int QW  = FRAC_BITS + 1;
    localparam int NMW = VW + FRAC_BITS;
    localparam int DW  = (NMW > VW + QW) ? NMW : VW + QW;
    localparam int CW  = (QW > MAG_W) ? QW : MAG_W;

    logic [NMW-1:0] rem_reg [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];
    logic [VW-1:0]  len_reg [QW+1];

    // Numerator stage: magnitude scaled to the output format plus half the length.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= (NMW'(mag) << FRAC_BITS) + NMW'(len >> 1);
            q_reg[0]   <= '0;
            len_reg[0] <= len;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= QW; j++)
        begin : g_step
            localparam int B = QW - j;
            logic [DW-1:0] den;
            logic          fits;

            assign den  = DW'(len_reg[j-1]) << B;
            assign fits = DW'(rem_reg[j-1]) >= den;

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= fits ? NMW'(DW'(rem_reg[j-1]) - den) : rem_reg[j-1];
                    q_reg[j]   <= fits ? (q_reg[j-1] | (QW'(1) << B)) : q_reg[j-1];
                    len_reg[j] <= len_reg[j-1];
                end
            end
        end
    endgenerate

    logic [CW-1:0] q_ext;
    assign q_ext = CW'(q_reg[QW]);
    assign quot  = (q_ext > CW'(32768)) ? MAG_W'(32768) : MAG_W'(q_ext);

endmodule
